[sv/bsvr_pkg.sv]
// ----------------------------------------------------------------------------
// bsvr_pkg
// Shared types and constants for the byte stack with value removal.
// ----------------------------------------------------------------------------
package bsvr_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 7;   // count/occupancy width (0..DEPTH)
  localparam int DW    = 8;

  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_PEEK   = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_REMOVE = 3'd4,
    FN_COUNT  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

endpackage

[sv/bsvr_ram.sv]
// ----------------------------------------------------------------------------
// bsvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsvr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/bsvr_ctrl.sv]
// ----------------------------------------------------------------------------
// bsvr_ctrl
// Sequencer and shared compare unit: runs one request at a time against the
// stack RAM, walking entries one per cycle for remove and count.
// ----------------------------------------------------------------------------
module bsvr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             func,
  input  logic [bsvr_pkg::DW-1:0] value,
  input  logic [bsvr_pkg::CW-1:0] cap_eff,
  output logic                   done,
  output logic [bsvr_pkg::DW-1:0] data,
  output logic [bsvr_pkg::CW-1:0] match_count,
  output logic [bsvr_pkg::CW-1:0] occupancy,
  output logic [1:0]             status,
  output logic                   ram_we,
  output logic [bsvr_pkg::AW-1:0] ram_waddr,
  output logic [bsvr_pkg::DW-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [bsvr_pkg::AW-1:0] ram_raddr,
  input  logic [bsvr_pkg::DW-1:0] ram_rdata
);
  import bsvr_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] top, top_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] kept, kept_next;
  logic [CW-1:0] hits, hits_next;
  func_t         op, op_next;
  logic [DW-1:0] val, val_next;
  logic          done_next;
  logic [DW-1:0] data_next;
  logic [CW-1:0] match_count_next, occupancy_next;
  status_t       status_q, status_next;

  logic [CW-1:0] top_dec;
  logic          hit;
  logic [CW-1:0] hits_inc, kept_inc;
  logic          last;

  assign top_dec  = top - CW'(1);
  assign hit      = (ram_rdata == val);
  assign hits_inc = hit ? hits + CW'(1) : hits;
  assign kept_inc = hit ? kept : kept + CW'(1);
  assign last     = (idx == top);
  assign busy     = (state != S_IDLE);
  assign status   = status_q;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (func_t'(func))
            FN_POP, FN_PEEK: begin
              if (top != '0) state_next = S_READ;
            end
            FN_REMOVE, FN_COUNT: begin
              if (top != '0) state_next = S_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_SCAN: begin
        if (last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    top_next         = top;
    idx_next         = idx;
    kept_next        = kept;
    hits_next        = hits;
    op_next          = op;
    val_next         = val;
    done_next        = 1'b0;
    data_next        = data;
    match_count_next = match_count;
    occupancy_next   = occupancy;
    status_next      = status_q;
    ram_we           = 1'b0;
    ram_waddr        = kept[AW-1:0];
    ram_wdata        = ram_rdata;
    ram_re           = 1'b0;
    ram_raddr        = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next          = func_t'(func);
          val_next         = value;
          data_next        = '0;
          match_count_next = '0;
          status_next      = ST_OK;
          occupancy_next   = top;
          case (func_t'(func))
            FN_PUSH: begin
              done_next = 1'b1;
              if (top >= cap_eff) begin
                status_next = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = top[AW-1:0];
                ram_wdata      = value;
                top_next       = top + CW'(1);
                occupancy_next = top + CW'(1);
              end
            end
            FN_POP, FN_PEEK: begin
              if (top == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = top_dec[AW-1:0];
              end
            end
            FN_CLEAR: begin
              done_next      = 1'b1;
              top_next       = '0;
              occupancy_next = '0;
            end
            FN_REMOVE, FN_COUNT: begin
              if (top == '0) begin
                done_next = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_next  = CW'(1);
                kept_next = '0;
                hits_next = '0;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      S_READ: begin
        done_next = 1'b1;
        data_next = ram_rdata;
        if (op == FN_POP) begin
          top_next       = top_dec;
          occupancy_next = top_dec;
        end
      end
      S_SCAN: begin
        // ram_rdata holds entry idx-1; kept <= idx-1, so the write never
        // lands on an entry still to be read
        hits_next = hits_inc;
        if (op == FN_REMOVE) begin
          kept_next = kept_inc;
          if (!hit) ram_we = 1'b1;
        end
        if (!last) begin
          ram_re   = 1'b1;
          idx_next = idx + CW'(1);
        end else begin
          done_next        = 1'b1;
          match_count_next = hits_inc;
          if (op == FN_REMOVE) begin
            top_next       = kept_inc;
            occupancy_next = kept_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      top   <= top_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    kept        <= kept_next;
    hits        <= hits_next;
    op          <= op_next;
    val         <= val_next;
    data        <= data_next;
    match_count <= match_count_next;
    occupancy   <= occupancy_next;
    status_q    <= status_next;
  end

endmodule

[sv/byte_stack_with_value_removal_core.sv]
// ----------------------------------------------------------------------------
// byte_stack_with_value_removal_core
// LIFO byte stack with programmable capacity, match removal and counting.
//
//   channel   signals                                   direction
//   request   start, busy, func, value                  in (busy out)
//   result    done, data, match_count, occupancy, status out
//   config    cfg_we, cfg_wdata (capacity)              in
//
// Push, clear and unused codes: busy stays low, done follows in the next cycle.
// Pop/peek: the RAM read is issued from idle and its data taken in S_READ;
// on an empty stack done follows in the next cycle. Remove/count: one stored
// entry per cycle through the single compare unit.
// busy is high while a request runs; done pulses one cycle per request.
// Synchronous reset empties the stack and sets capacity to its full depth.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module byte_stack_with_value_removal_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              func,
  input  logic [bsvr_pkg::DW-1:0] value,
  output logic                    done,
  output logic [bsvr_pkg::DW-1:0] data,
  output logic [bsvr_pkg::CW-1:0] match_count,
  output logic [bsvr_pkg::CW-1:0] occupancy,
  output logic [1:0]              status,
  input  logic                    cfg_we,
  input  logic [bsvr_pkg::CW-1:0] cfg_wdata
);
  import bsvr_pkg::*;

  logic [CW-1:0] capacity;
  logic [CW-1:0] cap_eff;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(DEPTH);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // zero acts as one, anything past the depth as the depth
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (capacity > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = capacity;
    end
  end

  bsvr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .value       (value),
    .cap_eff     (cap_eff),
    .done        (done),
    .data        (data),
    .match_count (match_count),
    .occupancy   (occupancy),
    .status      (status),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  bsvr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
